FILE: design/itp_pkg.sv
// Shared types and codes for the infix-to-postfix converter.
`timescale 1ns / 1ps
package itp_pkg;

	// Token kinds on the input word
	localparam logic [2:0] TOK_NUMBER   = 3'd0;
	localparam logic [2:0] TOK_VARIABLE = 3'd1;
	localparam logic [2:0] TOK_LBRACKET = 3'd2;
	localparam logic [2:0] TOK_RBRACKET = 3'd3;
	localparam logic [2:0] TOK_UNARY    = 3'd4;
	localparam logic [2:0] TOK_BINARY   = 3'd5;
	localparam logic [2:0] TOK_END      = 3'd6;

	// Kinds on the result word
	localparam logic [2:0] OUT_NUMBER   = 3'd0;
	localparam logic [2:0] OUT_VARIABLE = 3'd1;
	localparam logic [2:0] OUT_UNARY    = 3'd2;
	localparam logic [2:0] OUT_BINARY   = 3'd3;
	localparam logic [2:0] OUT_END      = 3'd4;

	// Error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [1:0] ERR_UNMATCHED = 2'd2;

	// Kinds of stacked entry
	localparam logic [1:0] ENT_LBRACKET = 2'd0;
	localparam logic [1:0] ENT_UNARY    = 2'd1;
	localparam logic [1:0] ENT_BINARY   = 2'd2;

	// Width of one stack entry
	localparam int ENTRY_W = 9;

	typedef struct packed {
		logic [2:0]  token_kind;
		logic [3:0]  op_code;
		logic [1:0]  op_priority;
		logic        is_power;
		logic [63:0] operand_value;
	} token_t;

	typedef struct packed {
		logic [2:0]  out_kind;
		logic [3:0]  out_op_code;
		logic [63:0] out_value;
		logic        last_of_run;
		logic [1:0]  error_code;
	} result_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       power;
		logic [1:0] prio;
		logic [3:0] op;
	} entry_t;

	// Status of the sequencer, seen by the top level
	typedef struct packed {
		logic busy;
		logic pend_valid;
	} seq_status_t;

	typedef enum logic [0:0] {
		S_IDLE,
		S_EVAL
	} state_t;

endpackage

FILE: design/itp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module itp_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port; read data holds when not enabled.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: design/itp_seq.sv
// Sequencer: token decode, stack pointer, bracket count and pop loop.
`timescale 1ns / 1ps
module itp_seq #(
	parameter int STACK_DEPTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           token_valid,
	input  itp_pkg::token_t                token,
	output logic                           token_stall,
	input  itp_pkg::entry_t                top_entry,
	output logic                           rd_en,
	output logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
	output logic                           wr_en,
	output logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
	output itp_pkg::entry_t                wr_data,
	input  logic                           out_free,
	output logic                           load_out,
	output itp_pkg::result_t               load_data,
	output itp_pkg::seq_status_t           status
);
	import itp_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t          state_q, state_d;
	token_t          tok_q;
	logic            first_q, first_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [CW-1:0]   lbr_q, lbr_d;
	logic            pend_valid_q, pend_valid_d;
	result_t         pend_q, pend_d;
	logic            accept;
	logic            done;
	logic            full;
	logic            empty;
	logic            stop;
	logic            can_move;
	logic [CW-1:0]   cnt_m1;
	logic [CW-1:0]   cnt_m2;
	result_t         err_res;
	result_t         pend_last;
	result_t         pend_more;

	// Operator result for a popped entry.
	function automatic result_t pop_result(entry_t e);
		result_t r;
		r = '0;
		r.out_kind    = (e.kind == ENT_UNARY) ? OUT_UNARY : OUT_BINARY;
		r.out_op_code = e.op;
		return r;
	endfunction

	assign accept      = token_valid && !token_stall;
	assign token_stall = (state_q != S_IDLE);
	assign full        = (cnt_q >= CW'(STACK_DEPTH));
	assign empty       = (cnt_q == '0);
	assign cnt_m1      = cnt_q - CW'(1);
	assign cnt_m2      = cnt_q - CW'(2);
	assign status      = '{busy: token_stall, pend_valid: pend_valid_q};

	// A held-back pop may leave only when the output register has room.
	assign can_move = !pend_valid_q || out_free;

	always_comb begin
		pend_last             = pend_q;
		pend_last.last_of_run = 1'b1;
		pend_more             = pend_q;
		pend_more.last_of_run = 1'b0;
		err_res               = '0;
		err_res.out_kind      = OUT_NUMBER;
		err_res.last_of_run   = 1'b1;
	end

	// The binary operator stops popping at an empty stack, a bracket, a lower
	// priority, or (on its first look only) a power sitting under a power.
	always_comb begin
		stop = empty || top_entry.kind == ENT_LBRACKET ||
			top_entry.prio < tok_q.op_priority ||
			(first_q && tok_q.is_power && top_entry.kind == ENT_BINARY && top_entry.power);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EVAL;
			end
			S_EVAL: begin
				if (done) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath and memory control. A token read is issued at accept, so the
	// top entry is ready in the evaluation cycle; each pop issues the next read.
	// A push and the next token's read fall in different cycles, so the RAM
	// needs no forwarding.
	always_comb begin
		rd_en        = accept;
		rd_addr      = cnt_m1[AW-1:0];
		wr_en        = 1'b0;
		wr_addr      = cnt_q[AW-1:0];
		wr_data      = '0;
		load_out     = 1'b0;
		load_data    = '0;
		cnt_d        = cnt_q;
		lbr_d        = lbr_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		first_d      = first_q;
		done         = 1'b0;

		if (accept) begin
			first_d      = 1'b1;
			pend_valid_d = 1'b0;
		end

		if (state_q == S_EVAL) begin
			case (tok_q.token_kind) inside
				TOK_NUMBER, TOK_VARIABLE: begin
					if (out_free) begin
						load_out              = 1'b1;
						load_data.out_kind    = (tok_q.token_kind == TOK_NUMBER) ?
							OUT_NUMBER : OUT_VARIABLE;
						load_data.out_value   = (tok_q.token_kind == TOK_NUMBER) ?
							tok_q.operand_value : '0;
						load_data.last_of_run = 1'b1;
						done                  = 1'b1;
					end
				end
				TOK_LBRACKET, TOK_UNARY: begin
					if (full) begin
						if (out_free) begin
							load_out             = 1'b1;
							load_data            = err_res;
							load_data.error_code = ERR_OVERFLOW;
							done                 = 1'b1;
						end
					end else begin
						wr_en = 1'b1;
						if (tok_q.token_kind == TOK_UNARY) begin
							wr_data.kind = ENT_UNARY;
							wr_data.prio = tok_q.op_priority;
							wr_data.op   = tok_q.op_code;
						end else begin
							wr_data.kind = ENT_LBRACKET;
							lbr_d        = lbr_q + CW'(1);
						end
						cnt_d = cnt_q + CW'(1);
						done  = 1'b1;
					end
				end
				TOK_RBRACKET: begin
					if (lbr_q == '0) begin
						if (out_free) begin
							load_out             = 1'b1;
							load_data            = err_res;
							load_data.error_code = ERR_UNMATCHED;
							done                 = 1'b1;
						end
					end else if (can_move) begin
						load_out  = pend_valid_q;
						load_data = (top_entry.kind == ENT_LBRACKET) ? pend_last : pend_more;
						if (top_entry.kind == ENT_LBRACKET) begin
							cnt_d        = cnt_m1;
							lbr_d        = lbr_q - CW'(1);
							pend_valid_d = 1'b0;
							done         = 1'b1;
						end else begin
							pend_d       = pop_result(top_entry);
							pend_valid_d = 1'b1;
							cnt_d        = cnt_m1;
							rd_en        = 1'b1;
							rd_addr      = cnt_m2[AW-1:0];
							first_d      = 1'b0;
						end
					end
				end
				TOK_BINARY: begin
					if (stop && full) begin
						if (out_free) begin
							load_out             = 1'b1;
							load_data            = err_res;
							load_data.error_code = ERR_OVERFLOW;
							done                 = 1'b1;
						end
					end else if (can_move) begin
						load_out  = pend_valid_q;
						load_data = stop ? pend_last : pend_more;
						if (stop) begin
							wr_en         = 1'b1;
							wr_data.kind  = ENT_BINARY;
							wr_data.power = tok_q.is_power;
							wr_data.prio  = tok_q.op_priority;
							wr_data.op    = tok_q.op_code;
							cnt_d         = cnt_q + CW'(1);
							pend_valid_d  = 1'b0;
							done          = 1'b1;
						end else begin
							pend_d       = pop_result(top_entry);
							pend_valid_d = 1'b1;
							cnt_d        = cnt_m1;
							rd_en        = 1'b1;
							rd_addr      = cnt_m2[AW-1:0];
							first_d      = 1'b0;
						end
					end
				end
				TOK_END: begin
					if (empty) begin
						if (out_free) begin
							load_out              = 1'b1;
							load_data.out_kind    = OUT_END;
							load_data.last_of_run = 1'b1;
							done                  = 1'b1;
						end
					end else if (top_entry.kind == ENT_LBRACKET) begin
						// Leftover brackets are dropped without a result.
						cnt_d   = cnt_m1;
						lbr_d   = lbr_q - CW'(1);
						rd_en   = 1'b1;
						rd_addr = cnt_m2[AW-1:0];
					end else if (out_free) begin
						load_out  = 1'b1;
						load_data = pop_result(top_entry);
						cnt_d     = cnt_m1;
						rd_en     = 1'b1;
						rd_addr   = cnt_m2[AW-1:0];
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			lbr_q        <= '0;
			pend_valid_q <= 1'b0;
			first_q      <= 1'b0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			lbr_q        <= lbr_d;
			pend_valid_q <= pend_valid_d;
			first_q      <= first_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			tok_q <= token;
		end
		pend_q <= pend_d;
	end

endmodule

FILE: design/infix_to_postfix_converter_core.sv
// Top level of the infix-to-postfix converter: stack RAM, sequencer, result register.
`timescale 1ns / 1ps
// Usage.
// Infix tokens enter on the token channel (token_valid, token_stall, token) and
// postfix results leave on the result channel (result_valid, result_stall,
// result). A word moves when valid is high and stall is low at a clock edge.
// Each token gives zero or more results; the final one of a token carries
// last_of_run. Errors (stack overflow, unmatched right bracket) come back as a
// single result with the error code, and the token is dropped.
// Timing: a token is evaluated in the cycle after it is taken, and each popped
// or discarded stack entry lengthens the evaluation, paced by the registered
// read of the operator stack RAM.
// A passed-through word, an error or a flushed operator is loaded into the
// result register when its token is evaluated; an operator popped by a bracket
// or a binary operator is first held back in a pending register, then loaded.
// The block takes one token at a time.
// The result register lets the next token be taken while a result waits; when
// the receiver stalls, the pop loop halts in place until the register drains.
// Reset clears the stack pointer, the bracket count and all valid flags; the
// stack RAM is not cleared, since only entries below the pointer are read.
module infix_to_postfix_converter_core #(
	parameter int STACK_DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             token_valid,
	output logic             token_stall,
	input  itp_pkg::token_t  token,
	output logic             result_valid,
	input  logic             result_stall,
	output itp_pkg::result_t result
);
	import itp_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);

	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	entry_t             wr_data;
	entry_t             top_entry;
	logic               out_free;
	logic               load_out;
	result_t            load_data;
	seq_status_t        status;
	logic               out_valid_q;
	result_t            out_q;

	// Operator stack storage.
	itp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(top_entry)
	);

	// Token sequencer.
	itp_seq #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.token_valid(token_valid),
		.token      (token),
		.token_stall(token_stall),
		.top_entry  (top_entry),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.out_free   (out_free),
		.load_out   (load_out),
		.load_data  (load_data),
		.status     (status)
	);

	// Result register: free when empty or being taken this cycle.
	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= load_data;
		end
	end

	// Checks on the sequencer and result register.
	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("result loaded while the result register was full");

	a_no_pending_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!status.busy |-> !status.pend_valid)
		else $error("held-back pop left behind after a token finished");

	a_last_ends_token: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && load_data.last_of_run) |=> !token_stall)
		else $error("token still busy after its final result");

	a_more_keeps_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && !load_data.last_of_run) |=> token_stall)
		else $error("token finished without a final result");

endmodule
